>>> design/mask_centroid_velocity_top_defines.svh
// ----------------------------------------------------------------------------
// mask_centroid_velocity_top_defines.svh - assertion macros
// Shorthand for the concurrent checks of the mask centroid block.
// ----------------------------------------------------------------------------
`ifndef MASK_CENTROID_VELOCITY_TOP_DEFINES_SVH
`define MASK_CENTROID_VELOCITY_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MCV_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define MCV_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> design/mcv_pkg.sv
// ----------------------------------------------------------------------------
// mcv_pkg - shared constants for the mask centroid block
// Field widths, register indexes, reset values and saturation limits.
// ----------------------------------------------------------------------------
package mcv_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     WIDTH_RESET    = 11'd640;
  localparam logic [CFG_W-1:0]     HEIGHT_RESET   = 11'd480;

  // Input beat fields
  localparam int MASK_W = 8;
  localparam int TIME_W = 32;
  localparam logic [MASK_W-1:0] OBJECT_VALUE = 8'd255;

  // Result beat fields
  localparam int POS_W    = 14;
  localparam int VEL_W    = 19;
  localparam int VEL_FRAC = 8;
  localparam logic [VEL_W-1:0] VEL_MAX = 19'h3FFFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 19'h40000;

  // Stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_POS_FRAC_BITS = 4;

endpackage

>>> design/mask_centroid_velocity_top.sv
// ----------------------------------------------------------------------------
// mask_centroid_velocity_top - binary mask centroid and velocity
// Sums the coordinates of object pixels over a raster frame, then divides
// with one shared restoring divider to get centroid and velocity.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// in_     | in  | one mask pixel with the frame timestamp
// out_    | out | centroid, velocity and status flags of one frame
// cfg_    | in  | frame width / height register writes
//
// Pixels are taken while idle; the last pixel of a frame also starts the
// divider: two divisions for the centroid and two for the velocity, each with
// a QW-bit quotient (QW = 18 at default parameters), then the result is posted.
// Zero elapsed time skips the velocity divisions; an empty mask skips all four.
// in_tready stays low from the last pixel until the result is posted; a stalled
// result beat holds the block in ST_DONE. Reset is synchronous.
// ----------------------------------------------------------------------------
`include "mask_centroid_velocity_top_defines.svh"

module mask_centroid_velocity_top
  import mcv_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: mask_value[7:0], frame_time[39:8]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: centroid_x[13:0], centroid_y[27:14], velocity_x[46:28],
  //            velocity_y[65:47], zero fill[71:66]
  // out_tuser: empty_mask[0], no_elapsed[1]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUMX_W  = COL_W + CNT_W;
  localparam int SUMY_W  = ROW_W + CNT_W;
  localparam int CRD_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int POSQ_W  = CRD_W + POS_FRAC_BITS;
  localparam int VMAG_W  = POS_W + VEL_FRAC - POS_FRAC_BITS;
  localparam int QW      = (POSQ_W > VMAG_W) ? POSQ_W : VMAG_W;
  localparam int DVS_W   = TIME_W;
  localparam int DIV_W   = QW + DVS_W;
  localparam int STP_W   = $clog2(QW);
  localparam int SAT_W   = ((QW > VEL_W) ? QW : VEL_W) + 1;
  localparam int WSZ_A   = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_A   = $clog2(MAX_HEIGHT + 1);
  localparam int WSZ_W   = (CFG_W > WSZ_A) ? CFG_W : WSZ_A;
  localparam int HSZ_W   = (CFG_W > HSZ_A) ? CFG_W : HSZ_A;
  localparam int VSH     = VEL_FRAC - POS_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_X, ST_DIV_Y, ST_DIV_VX, ST_DIV_VY, ST_DONE
  } state_t;

  // Registers
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    width_r, width_nxt;
  logic [CFG_W-1:0]    height_r, height_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SUMX_W-1:0]   sum_x_r, sum_x_nxt;
  logic [SUMY_W-1:0]   sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0]    prev_x_r, prev_x_nxt;
  logic [POS_W-1:0]    prev_y_r, prev_y_nxt;
  logic [TIME_W-1:0]   prev_time_r, prev_time_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic                empty_r, empty_nxt;
  logic                noel_r, noel_nxt;
  logic                neg_r, neg_nxt;
  logic [POS_W-1:0]    cx_r, cx_nxt;
  logic [POS_W-1:0]    cy_r, cy_nxt;
  logic [VEL_W-1:0]    vx_r, vx_nxt;
  logic [VEL_W-1:0]    vy_r, vy_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]       q_r, q_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [STP_W-1:0]    stp_r, stp_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    cx_out_r, cx_out_nxt;
  logic [POS_W-1:0]    cy_out_r, cy_out_nxt;
  logic [VEL_W-1:0]    vx_out_r, vx_out_nxt;
  logic [VEL_W-1:0]    vy_out_r, vy_out_nxt;
  logic                empty_out_r, empty_out_nxt;
  logic                noel_out_r, noel_out_nxt;

  // Combinational signals
  logic [MASK_W-1:0]   mask_value;
  logic [TIME_W-1:0]   frame_time;
  logic [WSZ_W-1:0]    w_eff;
  logic [HSZ_W-1:0]    h_eff;
  logic                in_acc;
  logic                hit;
  logic                col_end;
  logic                row_end;
  logic                frame_end;
  logic [SUMX_W-1:0]   sum_x_add;
  logic [SUMY_W-1:0]   sum_y_add;
  logic [CNT_W-1:0]    cnt_add;
  logic [DVS_W:0]      div_ext;
  logic                div_ge;
  logic [DVS_W-1:0]    rem_step;
  logic [QW-1:0]       q_step;
  logic                div_last;
  logic                ld;
  logic [DIV_W-1:0]    ld_dvd;
  logic [DVS_W-1:0]    ld_dvs;
  logic                vsel_y;
  logic [POS_W-1:0]    v_cur;
  logic [POS_W-1:0]    v_prv;
  logic                v_neg;
  logic [POS_W-1:0]    v_mag;
  logic [DIV_W-1:0]    v_dvd;
  logic [SAT_W-1:0]    q_ext;
  logic [VEL_W-1:0]    vel_sat;
  logic                div_busy;
  logic                out_vel_zero;
  logic                out_all_zero;

  assign mask_value = in_tdata[MASK_W-1:0];
  assign frame_time = in_tdata[MASK_W +: TIME_W];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // Clamp the frame size to 1 .. maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = WSZ_W'(1);
    end else if (WSZ_W'(width_r) > WSZ_W'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HSZ_W'(1);
    end else if (HSZ_W'(height_r) > HSZ_W'(MAX_HEIGHT)) begin
      h_eff = HSZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = HSZ_W'(height_r);
    end
  end

  // Raster position and accumulation of object pixels
  assign hit       = (mask_value == OBJECT_VALUE);
  assign col_end   = (WSZ_W'(col_r) + WSZ_W'(1)) >= w_eff;
  assign row_end   = (HSZ_W'(row_r) + HSZ_W'(1)) >= h_eff;
  assign frame_end = col_end && row_end;
  assign sum_x_add = sum_x_r + (hit ? SUMX_W'(col_r) : '0);
  assign sum_y_add = sum_y_r + (hit ? SUMY_W'(row_r) : '0);
  assign cnt_add   = cnt_r + (hit ? CNT_W'(1) : '0);

  // One restoring divide step: shift in a dividend bit, subtract if it fits
  assign div_ext  = {rem_r, q_r[QW-1]};
  assign div_ge   = div_ext >= {1'b0, dvs_r};
  assign rem_step = div_ge ? DVS_W'(div_ext - {1'b0, dvs_r}) : div_ext[DVS_W-1:0];
  assign q_step   = {q_r[QW-2:0], div_ge};
  assign div_last = (stp_r == '0);

  // Velocity dividend: scaled magnitude of the centroid change
  assign vsel_y = (state_r == ST_DIV_VX);
  assign v_cur  = vsel_y ? cy_r : cx_r;
  assign v_prv  = vsel_y ? prev_y_r : prev_x_r;
  assign v_neg  = v_cur < v_prv;
  assign v_mag  = v_neg ? (v_prv - v_cur) : (v_cur - v_prv);
  assign v_dvd  = DIV_W'(v_mag) << VSH;

  // Saturate the signed velocity quotient
  assign q_ext = SAT_W'(q_step);
  always_comb begin
    if (neg_r) begin
      vel_sat = (q_ext > SAT_W'(VEL_MIN)) ? VEL_MIN : VEL_W'(~q_ext + SAT_W'(1));
    end else begin
      vel_sat = (q_ext > SAT_W'(VEL_MAX)) ? VEL_MAX : VEL_W'(q_ext);
    end
  end

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    cnt_nxt       = cnt_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_time_nxt = prev_time_r;
    elapsed_nxt   = elapsed_r;
    empty_nxt     = empty_r;
    noel_nxt      = noel_r;
    neg_nxt       = neg_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    out_valid_nxt = out_valid_r;
    cx_out_nxt    = cx_out_r;
    cy_out_nxt    = cy_out_r;
    vx_out_nxt    = vx_out_r;
    vy_out_nxt    = vy_out_r;
    empty_out_nxt = empty_out_r;
    noel_out_nxt  = noel_out_r;
    ld            = 1'b0;
    ld_dvd        = '0;
    ld_dvs        = '0;

    // Register writes
    if (cfg_we && (cfg_index == CFG_IDX_WIDTH)) begin
      width_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == CFG_IDX_HEIGHT)) begin
      height_nxt = cfg_wdata;
    end

    // Drop the result beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sum_x_nxt = sum_x_add;
          sum_y_nxt = sum_y_add;
          cnt_nxt   = cnt_add;
          if (col_end) begin
            col_nxt = '0;
            row_nxt = row_end ? '0 : (row_r + ROW_W'(1));
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          if (frame_end) begin
            elapsed_nxt   = frame_time - prev_time_r;
            prev_time_nxt = frame_time;
            empty_nxt     = (cnt_add == '0);
            noel_nxt      = (frame_time == prev_time_r);
            cx_nxt        = '0;
            cy_nxt        = '0;
            vx_nxt        = '0;
            vy_nxt        = '0;
            if (cnt_add == '0) begin
              state_nxt = ST_DONE;
            end else begin
              ld        = 1'b1;
              ld_dvd    = DIV_W'(sum_x_add) << POS_FRAC_BITS;
              ld_dvs    = DVS_W'(cnt_add);
              state_nxt = ST_DIV_X;
            end
          end
        end
      end
      ST_DIV_X: begin
        if (div_last) begin
          cx_nxt    = POS_W'(q_step);
          ld        = 1'b1;
          ld_dvd    = DIV_W'(sum_y_r) << POS_FRAC_BITS;
          ld_dvs    = DVS_W'(cnt_r);
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_last) begin
          cy_nxt = POS_W'(q_step);
          if (noel_r) begin
            state_nxt = ST_DONE;
          end else begin
            ld        = 1'b1;
            ld_dvd    = v_dvd;
            ld_dvs    = elapsed_r;
            neg_nxt   = v_neg;
            state_nxt = ST_DIV_VX;
          end
        end
      end
      ST_DIV_VX: begin
        if (div_last) begin
          vx_nxt    = vel_sat;
          ld        = 1'b1;
          ld_dvd    = v_dvd;
          ld_dvs    = elapsed_r;
          neg_nxt   = v_neg;
          state_nxt = ST_DIV_VY;
        end
      end
      ST_DIV_VY: begin
        if (div_last) begin
          vy_nxt    = vel_sat;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Post the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          cx_out_nxt    = cx_r;
          cy_out_nxt    = cy_r;
          vx_out_nxt    = vx_r;
          vy_out_nxt    = vy_r;
          empty_out_nxt = empty_r;
          noel_out_nxt  = noel_r;
          if (!empty_r && !noel_r) begin
            prev_x_nxt = cx_r;
            prev_y_nxt = cy_r;
          end
          sum_x_nxt = '0;
          sum_y_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance the divider, or load fresh operands
    if (ld) begin
      rem_nxt = ld_dvd[DIV_W-1:QW];
      q_nxt   = ld_dvd[QW-1:0];
      dvs_nxt = ld_dvs;
      stp_nxt = STP_W'(QW - 1);
    end else begin
      rem_nxt = rem_step;
      q_nxt   = q_step;
      dvs_nxt = dvs_r;
      stp_nxt = stp_r - STP_W'(1);
    end
  end

  // State, registered outputs and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      cnt_r       <= cnt_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_time_r <= prev_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
    elapsed_r   <= elapsed_nxt;
    empty_r     <= empty_nxt;
    noel_r      <= noel_nxt;
    neg_r       <= neg_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    dvs_r       <= dvs_nxt;
    stp_r       <= stp_nxt;
    cx_out_r    <= cx_out_nxt;
    cy_out_r    <= cy_out_nxt;
    vx_out_r    <= vx_out_nxt;
    vy_out_r    <= vy_out_nxt;
    empty_out_r <= empty_out_nxt;
    noel_out_r  <= noel_out_nxt;
  end

  // Output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * POS_W - 2 * VEL_W){1'b0}},
                       vy_out_r, vx_out_r, cy_out_r, cx_out_r};
  assign out_tuser  = {noel_out_r, empty_out_r};

  // Checks
  assign div_busy     = (state_r == ST_DIV_X) || (state_r == ST_DIV_Y) ||
                        (state_r == ST_DIV_VX) || (state_r == ST_DIV_VY);
  assign out_vel_zero = (vx_out_r == '0) && (vy_out_r == '0);
  assign out_all_zero = out_vel_zero && (cx_out_r == '0) && (cy_out_r == '0);
  `MCV_CHECK(a_rem_below_divisor, div_busy |-> (rem_r < dvs_r), "remainder not below divisor")
  `MCV_CHECK_NEXT(a_frame_end_stalls_input, in_acc && frame_end, !in_tready, "input open at end")
  `MCV_CHECK(a_empty_reports_zero, (out_tvalid && empty_out_r) |-> out_all_zero, "empty nonzero")
  `MCV_CHECK(a_no_elapsed_zero_velocity, (out_tvalid && noel_out_r) |-> out_vel_zero, "velocity set")

endmodule
